// ----- rtl/cdg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdg_pkg
// Shared constants and types of the central-difference gradient volume unit.
// ----------------------------------------------------------------------------
package cdg_pkg;

   localparam int VOXEL_W   = 16;
   localparam int GRAD_W    = 17;
   localparam int MAG_W     = 17;
   localparam int SIZE_XY_W = 9;
   localparam int SIZE_Z_W  = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;

   // five 17-bit fields, padded to whole bytes
   localparam int RSP_DATA_W = 88;

   localparam int DEF_MAX_X = 256;
   localparam int DEF_MAX_Y = 256;
   localparam int DEF_MAX_Z = 1024;

   localparam int RESET_SIZE = 256;
   localparam int MIN_SIZE   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X = 2'd0,
      CSR_SIZE_Y = 2'd1,
      CSR_SIZE_Z = 2'd2
   } csr_index_type;

endpackage

// ----- rtl/central_difference_gradient_volume_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// central_difference_gradient_volume_unit
// Streaming 3-D central-difference gradient with magnitude and running peak.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: voxel_value
//  rsp     | out | rsp_tvalid/tready    | tdata: gx,gy,gz,magnitude,peak; tlast
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// A voxel with a gradient passes the accept step and one more plane-store
// read step, y gradient, squares, sum, the bit-serial square root and the
// output load. A first-plane voxel passes only the accept and read steps.
// Plane stores are two ping-pong memories; a plane swap toggles a select bit.
// Reset is synchronous; stores are not cleared. A stalled result register
// holds the unit in its output step until the beat is taken.
module central_difference_gradient_volume_unit #(
   parameter int MAX_X = cdg_pkg::DEF_MAX_X,
   parameter int MAX_Y = cdg_pkg::DEF_MAX_Y,
   parameter int MAX_Z = cdg_pkg::DEF_MAX_Z
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cdg_pkg::VOXEL_W-1:0]     req_tdata,   // [15:0] voxel_value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [16:0] grad_x, [33:17] grad_y, [50:34] grad_z, [67:51] magnitude,
   // [84:68] peak_magnitude, [87:85] zero
   output logic [cdg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,   // is_last
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cdg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cdg_pkg::CSR_DAT_W-1:0]   csr_data
);
   import cdg_pkg::*;

   localparam int XW     = $clog2(MAX_X);
   localparam int YW     = $clog2(MAX_Y);
   localparam int ZW     = $clog2(MAX_Z);
   localparam int SXW    = $clog2(MAX_X + 1);
   localparam int SYW    = $clog2(MAX_Y + 1);
   localparam int SZW    = $clog2(MAX_Z + 1);
   localparam int DEPTH  = MAX_X * MAX_Y;
   localparam int AW     = $clog2(DEPTH);
   localparam int SQ_W   = 2 * GRAD_W;
   localparam int RAD_W  = 2 * MAG_W;
   localparam int REM_W  = MAG_W + 2;
   localparam int TRY_W  = MAG_W + 4;
   localparam int ITER_W = $clog2(MAG_W);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_READ2  = 7'b0000010,
      ST_GRADY  = 7'b0000100,
      ST_SQUARE = 7'b0001000,
      ST_SUM    = 7'b0010000,
      ST_ROOT   = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   function automatic int clamp_size(input int raw, input int top);
      int r;
      r = raw;
      if (r < MIN_SIZE) r = MIN_SIZE;
      if (r > top) r = top;
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [SXW-1:0] size_x_ff;
   logic [SYW-1:0] size_y_ff;
   logic [SZW-1:0] size_z_ff;
   logic [XW-1:0]  pos_x_ff;
   logic [YW-1:0]  pos_y_ff;
   logic [ZW-1:0]  pos_z_ff;
   logic           sel_ff;       // 1: mem1 holds the older plane
   logic [MAG_W-1:0] peak_ff;

   logic [AW-1:0]      addr_ff;
   logic [VOXEL_W-1:0] voxel_ff;
   logic               border_ff, last_ff, emit_ff;
   logic               plane_end_ff, vol_end_ff, row_end_ff;

   logic signed [GRAD_W-1:0] gx_ff, gy_ff, gz_ff;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff, sqz_ff;
   logic [RAD_W-1:0] rad_ff;
   logic [REM_W-1:0] rem_ff;
   logic [MAG_W-1:0] root_ff;
   logic [ITER_W-1:0] iter_ff;

   logic rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic rsp_last_ff;

   logic [VOXEL_W-1:0] mem0 [0:DEPTH-1];
   logic [VOXEL_W-1:0] mem1 [0:DEPTH-1];
   logic [VOXEL_W-1:0] rd0a_ff, rd0b_ff, rd1a_ff, rd1b_ff;

   logic req_fire, csr_fire, out_free;
   logic [AW-1:0] pos_addr, cur_addr, prev_a_addr, prev_b_addr;
   logic [AW-1:0] ra0a, ra0b, ra1a, ra1b;
   logic [VOXEL_W-1:0] prev_a, prev_b, older_a;
   logic x_at_end, y_at_end, z_at_end;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign x_at_end = ({{(SXW-XW){1'b0}}, pos_x_ff} == size_x_ff - SXW'(1));
   assign y_at_end = ({{(SYW-YW){1'b0}}, pos_y_ff} == size_y_ff - SYW'(1));
   assign z_at_end = ({{(SZW-ZW){1'b0}}, pos_z_ff} == size_z_ff - SZW'(1));

   assign pos_addr = AW'(pos_y_ff) * AW'(MAX_X) + AW'(pos_x_ff);
   assign cur_addr = (state_ff == ST_IDLE) ? pos_addr : addr_ff;

   // neighbors along x first, then along y; border voxels may wrap harmlessly
   assign prev_a_addr = (state_ff == ST_IDLE) ? cur_addr - AW'(1) : cur_addr - AW'(MAX_X);
   assign prev_b_addr = (state_ff == ST_IDLE) ? cur_addr + AW'(1) : cur_addr + AW'(MAX_X);

   assign ra0a = sel_ff ? prev_a_addr : cur_addr;
   assign ra0b = sel_ff ? prev_b_addr : cur_addr;
   assign ra1a = sel_ff ? cur_addr : prev_a_addr;
   assign ra1b = sel_ff ? cur_addr : prev_b_addr;

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ2 && !sel_ff) begin
         mem0[addr_ff] <= voxel_ff;
      end
      rd0a_ff <= mem0[ra0a];
      rd0b_ff <= mem0[ra0b];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ2 && sel_ff) begin
         mem1[addr_ff] <= voxel_ff;
      end
      rd1a_ff <= mem1[ra1a];
      rd1b_ff <= mem1[ra1b];
   end

   assign prev_a  = sel_ff ? rd0a_ff : rd1a_ff;
   assign prev_b  = sel_ff ? rd0b_ff : rd1b_ff;
   assign older_a = sel_ff ? rd1a_ff : rd0a_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_READ2;
         ST_READ2:  state_in = emit_ff ? ST_GRADY : ST_IDLE;
         ST_GRADY:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_ROOT;
         ST_ROOT:   if (iter_ff == ITER_W'(MAG_W - 1)) state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sizes, position, plane select and running peak
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SXW'(clamp_size(RESET_SIZE, MAX_X));
         size_y_ff <= SYW'(clamp_size(RESET_SIZE, MAX_Y));
         size_z_ff <= SZW'(clamp_size(RESET_SIZE, MAX_Z));
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         pos_z_ff  <= '0;
         sel_ff    <= 1'b0;
         peak_ff   <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_SIZE_X: size_x_ff <= SXW'(clamp_size(int'(csr_data[SIZE_XY_W-1:0]), MAX_X));
            CSR_SIZE_Y: size_y_ff <= SYW'(clamp_size(int'(csr_data[SIZE_XY_W-1:0]), MAX_Y));
            CSR_SIZE_Z: size_z_ff <= SZW'(clamp_size(int'(csr_data[SIZE_Z_W-1:0]), MAX_Z));
            default: ;
         endcase
         if (csr_index == CSR_SIZE_X || csr_index == CSR_SIZE_Y ||
             csr_index == CSR_SIZE_Z) begin
            pos_x_ff <= '0;
            pos_y_ff <= '0;
            pos_z_ff <= '0;
            peak_ff  <= '0;
         end
      end else begin
         if (state_ff == ST_READ2) begin
            if (row_end_ff) begin
               pos_x_ff <= '0;
               if (plane_end_ff) begin
                  pos_y_ff <= '0;
                  sel_ff   <= !sel_ff;
                  pos_z_ff <= vol_end_ff ? '0 : pos_z_ff + ZW'(1);
               end else begin
                  pos_y_ff <= pos_y_ff + YW'(1);
               end
            end else begin
               pos_x_ff <= pos_x_ff + XW'(1);
            end
         end
         if (state_ff == ST_OUT && out_free) begin
            peak_ff <= last_ff ? '0 : ((root_ff > peak_ff) ? root_ff : peak_ff);
         end
      end
   end

   // per-voxel datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         addr_ff      <= pos_addr;
         voxel_ff     <= req_tdata;
         emit_ff      <= (pos_z_ff != '0);
         border_ff    <= (pos_x_ff == '0) || x_at_end || (pos_y_ff == '0) || y_at_end ||
                         (pos_z_ff == ZW'(1));
         last_ff      <= x_at_end && y_at_end && z_at_end;
         row_end_ff   <= x_at_end;
         plane_end_ff <= x_at_end && y_at_end;
         vol_end_ff   <= x_at_end && y_at_end && z_at_end;
      end
      unique case (state_ff)
         ST_READ2: begin
            gx_ff <= border_ff ? '0 : GRAD_W'(signed'({1'b0, prev_b}) - signed'({1'b0, prev_a}));
            gz_ff <= border_ff ? '0 : GRAD_W'(signed'({1'b0, voxel_ff}) -
                                              signed'({1'b0, older_a}));
         end
         ST_GRADY: begin
            gy_ff <= border_ff ? '0 : GRAD_W'(signed'({1'b0, prev_b}) - signed'({1'b0, prev_a}));
         end
         ST_SQUARE: begin
            sqx_ff <= SQ_W'(gx_ff * gx_ff);
            sqy_ff <= SQ_W'(gy_ff * gy_ff);
            sqz_ff <= SQ_W'(gz_ff * gz_ff);
         end
         ST_SUM: begin
            rad_ff  <= RAD_W'(sqx_ff + sqy_ff + sqz_ff);
            rem_ff  <= '0;
            root_ff <= '0;
            iter_ff <= '0;
         end
         ST_ROOT: begin : root_step
            logic [TRY_W-1:0] rem_t, trial;
            rem_t = {rem_ff, rad_ff[RAD_W-1 -: 2]};
            trial = {2'b00, root_ff, 2'b01};
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            iter_ff <= iter_ff + ITER_W'(1);
            if (rem_t >= trial) begin
               rem_ff  <= REM_W'(rem_t - trial);
               root_ff <= {root_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_ff  <= REM_W'(rem_t);
               root_ff <= {root_ff[MAG_W-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= {3'b000, ((root_ff > peak_ff) ? root_ff : peak_ff), root_ff,
                         gz_ff, gy_ff, gx_ff};
         rsp_last_ff <= last_ff;
      end
   end

endmodule

// ----- tb/sv/central_difference_gradient_volume_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// central_difference_gradient_volume_unit_test
// Streams voxel volumes of many sizes through the gradient unit under random
// idling and stalls, predicts every gradient beat and compares it field by
// field.
// ----------------------------------------------------------------------------

typedef struct {
   logic signed [cdg_pkg::GRAD_W-1:0] gx;
   logic signed [cdg_pkg::GRAD_W-1:0] gy;
   logic signed [cdg_pkg::GRAD_W-1:0] gz;
   logic [cdg_pkg::MAG_W-1:0]         mag;
   logic [cdg_pkg::MAG_W-1:0]         peak;
   logic                              last;
} gradient_beat;

class gradient_scoreboard;
   localparam int PLANE_X = cdg_pkg::DEF_MAX_X;
   localparam int PLANE_WORDS = cdg_pkg::DEF_MAX_X * cdg_pkg::DEF_MAX_Y;

   logic [15:0] plane_mem [2][PLANE_WORDS];
   bit older_sel;
   int unsigned reg_x, reg_y, reg_z;
   int unsigned px, py, pz;
   logic [16:0] peak;
   gradient_beat expected_q[$];
   int errors;

   function new();
      reg_x = cdg_pkg::RESET_SIZE;
      reg_y = cdg_pkg::RESET_SIZE;
      reg_z = cdg_pkg::RESET_SIZE;
      older_sel = 0;
      errors = 0;
      restart_volume();
   endfunction

   function void restart_volume();
      px = 0;
      py = 0;
      pz = 0;
      peak = 0;
   endfunction

   function int unsigned fit_size(int unsigned raw, int unsigned top);
      if (raw < cdg_pkg::MIN_SIZE) return cdg_pkg::MIN_SIZE;
      if (raw > top) return top;
      return raw;
   endfunction

   function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function void write_reg(cdg_pkg::csr_index_type idx, logic [10:0] d);
      case (idx)
         cdg_pkg::CSR_SIZE_X: reg_x = d[8:0];
         cdg_pkg::CSR_SIZE_Y: reg_y = d[8:0];
         cdg_pkg::CSR_SIZE_Z: reg_z = d;
         default: return;
      endcase
      restart_volume();
   endfunction

   function void note_voxel(logic [15:0] v);
      int unsigned sx, sy, sz, i;
      int gx, gy, gz;
      longint unsigned sum;
      logic [16:0] mag;
      gradient_beat r;
      sx = fit_size(reg_x, cdg_pkg::DEF_MAX_X);
      sy = fit_size(reg_y, cdg_pkg::DEF_MAX_Y);
      sz = fit_size(reg_z, cdg_pkg::DEF_MAX_Z);
      if (px >= sx || py >= sy || pz >= sz) restart_volume();
      i = py * PLANE_X + px;
      if (pz >= 1) begin
         gx = 0;
         gy = 0;
         gz = 0;
         mag = 0;
         if (!(px == 0 || px == sx - 1 || py == 0 || py == sy - 1 || pz == 1)) begin
            gx = int'(plane_mem[!older_sel][i+1]) - int'(plane_mem[!older_sel][i-1]);
            gy = int'(plane_mem[!older_sel][i+PLANE_X])
               - int'(plane_mem[!older_sel][i-PLANE_X]);
            gz = int'(v) - int'(plane_mem[older_sel][i]);
            sum = longint'(gx) * gx + longint'(gy) * gy + longint'(gz) * gz;
            mag = 17'(int_sqrt(sum));
         end
         if (mag > peak) peak = mag;
         r.gx = gx[16:0];
         r.gy = gy[16:0];
         r.gz = gz[16:0];
         r.mag = mag;
         r.peak = peak;
         r.last = (px == sx - 1) && (py == sy - 1) && (pz == sz - 1);
         expected_q.push_back(r);
      end
      plane_mem[older_sel][i] = v;
      px++;
      if (px == sx) begin
         px = 0;
         py++;
         if (py == sy) begin
            py = 0;
            older_sel = !older_sel;
            pz++;
            if (pz == sz) begin
               pz = 0;
               peak = 0;
            end
         end
      end
   endfunction

   function void check_result(logic [cdg_pkg::RSP_DATA_W-1:0] d, logic l);
      gradient_beat e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected gradient beat data=%h last=%b", $time, d, l);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (d[16:0] !== e.gx) begin
         $display("%0t: grad_x expected %0d actual %0d", $time, e.gx, $signed(d[16:0]));
         errors++;
      end
      if (d[33:17] !== e.gy) begin
         $display("%0t: grad_y expected %0d actual %0d", $time, e.gy, $signed(d[33:17]));
         errors++;
      end
      if (d[50:34] !== e.gz) begin
         $display("%0t: grad_z expected %0d actual %0d", $time, e.gz, $signed(d[50:34]));
         errors++;
      end
      if (d[67:51] !== e.mag) begin
         $display("%0t: magnitude expected %0d actual %0d", $time, e.mag, d[67:51]);
         errors++;
      end
      if (d[84:68] !== e.peak) begin
         $display("%0t: peak expected %0d actual %0d", $time, e.peak, d[84:68]);
         errors++;
      end
      if (l !== e.last) begin
         $display("%0t: last expected %b actual %b", $time, e.last, l);
         errors++;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module central_difference_gradient_volume_unit_test;
   import cdg_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 50000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [VOXEL_W-1:0] req_tdata = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SIZE_X;
   logic [CSR_DAT_W-1:0] csr_data = 0;

   gradient_scoreboard gradients = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_req = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   central_difference_gradient_volume_unit dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) gradients.check_result(rsp_tdata, rsp_tlast);
      if (req_tvalid && req_tready) gradients.note_voxel(req_tdata);
      if (csr_valid && csr_ready) gradients.write_reg(csr_index_type'(csr_index), csr_data);
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = 300;
         hold_req = 0;
      end
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_voxel(logic [15:0] v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      // let the monitor note the last accepted voxel first
      @(posedge clock);
      while (gradients.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(csr_index_type idx, logic [10:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [10:0] pick_size(int top);
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(3, 7);
      if (r < 88) return $urandom_range(0, 2);
      if (r < 94) return top;
      return $urandom_range(0, 2047);
   endfunction

   function automatic logic [15:0] pick_voxel();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 16'h0000;
      if (r < 10) return 16'hffff;
      return $urandom_range(0, 65535);
   endfunction

   // 3x3x3 volume whose center voxel sees the steepest possible rise or fall
   task automatic send_steep_cube(bit falling);
      logic [15:0] v;
      for (int k = 0; k < 27; k++) begin
         v = (k % 3 == 2 || (k / 3) % 3 == 2 || k / 9 == 2) ? 16'hffff : 16'h0000;
         send_voxel(falling ? ~v : v);
      end
   endtask

   initial begin
      int unsigned sx, sy, sz, full, n;
      logic [10:0] wx, wy, wz;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_size(CSR_SIZE_X, 11'd3);
      write_size(CSR_SIZE_Y, 11'd3);
      write_size(CSR_SIZE_Z, 11'd3);
      // long receiver hold-off while the cubes keep coming, so the input stalls
      hold_req = 1;
      send_steep_cube(0);
      send_steep_cube(1);   // starts a second volume right at the wrap
      drain_results();
      write_size(CSR_SIZE_X, 11'h7ff);   // masked to 511, used as the largest width
      write_size(CSR_SIZE_Y, 11'd0);
      write_size(CSR_SIZE_Z, 11'd2047);
      for (int k = 0; k < 256 + 40; k++) send_voxel(pick_voxel());
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 86; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 86; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
         endcase
         n = 0;
         while (n < 150) begin
            wx = pick_size(DEF_MAX_X);
            wy = pick_size(DEF_MAX_Y);
            wz = ($urandom_range(99) < 95) ? pick_size(3) : 11'(DEF_MAX_Z);
            write_size(CSR_SIZE_X, wx);
            write_size(CSR_SIZE_Y, wy);
            write_size(CSR_SIZE_Z, wz);
            sx = gradients.fit_size(wx[8:0], DEF_MAX_X);
            sy = gradients.fit_size(wy[8:0], DEF_MAX_Y);
            sz = gradients.fit_size(wz, DEF_MAX_Z);
            full = sx * sy * sz;
            if (full > 400) full = 400;
            // mostly whole volumes, sometimes cut short or running into the next one
            full = $urandom_range(99) < 70 ? full : $urandom_range(1, full + full / 2);
            for (int k = 0; k < full; k++) send_voxel(pick_voxel());
            n += full;
            drain_results();
         end
      end

      drain_results();
      if (gradients.errors == 0 && gradients.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
